FILE: rtl/time_text_to_microseconds_defines.svh
// Assertion macros shared by the time text parser RTL.
`ifndef TIME_TEXT_TO_MICROSECONDS_DEFINES_SVH
`define TIME_TEXT_TO_MICROSECONDS_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TTU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TTU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ttu_pkg.sv
// Types and constants for the time text to microseconds parser.
package ttu_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NON_DIGIT = 2'd1,
    STAT_MINUTE    = 2'd2,
    STAT_SECOND    = 2'd3
  } status_t;

  // Character positions in HH:MM:SS.uuuuuu
  localparam logic [3:0] POS_HOUR_HI = 4'd0;
  localparam logic [3:0] POS_HOUR_LO = 4'd1;
  localparam logic [3:0] POS_SEP_0   = 4'd2;
  localparam logic [3:0] POS_MIN_HI  = 4'd3;
  localparam logic [3:0] POS_MIN_LO  = 4'd4;
  localparam logic [3:0] POS_SEP_1   = 4'd5;
  localparam logic [3:0] POS_SEC_HI  = 4'd6;
  localparam logic [3:0] POS_SEC_LO  = 4'd7;
  localparam logic [3:0] POS_SEP_2   = 4'd8;
  localparam logic [3:0] POS_LAST    = 4'd14;

  // Arithmetic constants
  localparam logic [18:0] SECS_PER_HOUR = 19'd3600;
  localparam logic [18:0] SECS_PER_MIN  = 19'd60;
  localparam logic [6:0]  PAIR_LIMIT    = 7'd60;
  localparam logic [19:0] US_PER_SEC    = 20'd1000000;
  localparam logic [7:0]  CHAR_ZERO     = 8'h30;
  localparam logic [7:0]  CHAR_NINE     = 8'h39;

  // Running parse state
  typedef struct packed {
    logic [3:0]  char_pos;
    logic [18:0] whole_seconds;
    logic [6:0]  pair_value;
    logic [19:0] micro_part;
    logic        skipping;
  } parse_state_t;

  // One result from a parse step
  typedef struct packed {
    logic        valid;
    logic [38:0] total_us;
    status_t     status;
    logic [3:0]  fail_pos;
  } parse_result_t;

endpackage

FILE: rtl/time_text_to_microseconds.sv
// Top level of the HH:MM:SS.uuuuuu time text to microseconds parser.
//
// Input channel (in_valid / in_stall): one ASCII character per request,
// in_first marks the first character of a record and restarts parsing.
// Until the first record start after reset, characters count from position 0.
// Output channel (out_valid / out_stall): one request per record, either the
// total in microseconds (status ok, fail_pos 14) or the first error found
// (non-digit, minute >= 60, second >= 60) with total zero. Characters after
// a result are dropped until the next record start.
// Throughput: one character per cycle while the receiver does not stall, set by
// the combinational parse step between the input register and the result register.
// A result is registered in the result register as its last character leaves the input register.
// When the receiver stalls, the result register holds; one more character
// is absorbed into the input register, then in_stall rises until the held
// result leaves.
// Reset (synchronous, rst_n low) clears the parse state and both valid flags.
`include "time_text_to_microseconds_defines.svh"

module time_text_to_microseconds (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_first,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [38:0] out_total_us,
  output logic [1:0]  out_status,
  output logic [3:0]  out_fail_pos
);
  import ttu_pkg::*;

  logic          s1_valid_r, s1_valid_nxt;
  logic [7:0]    s1_ch_r;
  logic          s1_first_r;
  parse_state_t  state_r, state_nxt;
  parse_result_t step_res;
  logic          advance;
  logic          out_valid_r, out_valid_nxt;
  logic [38:0]   out_total_us_r;
  status_t       out_status_r;
  logic [3:0]    out_fail_pos_r;

  // Parse step on the registered character
  ttu_step u_step (
    .cur_state  (state_r),
    .ch         (s1_ch_r),
    .first      (s1_first_r),
    .next_state (state_nxt),
    .result     (step_res)
  );

  // Stage moves when the result register is free or draining
  assign advance  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    s1_valid_nxt = in_stall ? s1_valid_r : in_valid;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (!in_stall && in_valid) begin
      s1_ch_r    <= in_ch;
      s1_first_r <= in_first;
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register valid
  always_comb begin
    if (advance && step_res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance && step_res.valid) begin
      out_total_us_r <= step_res.total_us;
      out_status_r   <= step_res.status;
      out_fail_pos_r <= step_res.fail_pos;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_total_us = out_total_us_r;
  assign out_status   = out_status_r;
  assign out_fail_pos = out_fail_pos_r;

  // Checks
  `TTU_ASSERT_IMP(a_err_zero, out_valid_r && (out_status_r != STAT_OK), out_total_us_r == '0, "error result carries a nonzero total")
  `TTU_ASSERT_IMP(a_ok_pos, out_valid_r && (out_status_r == STAT_OK), out_fail_pos_r == POS_LAST, "ok result with wrong position")
  `TTU_ASSERT_IMP(a_pos_range, !state_r.skipping, state_r.char_pos <= POS_LAST, "position past end while parsing")
  `TTU_ASSERT_NXT(a_skip_after, advance && step_res.valid, state_r.skipping && out_valid_r, "result did not stop parsing")

endmodule

FILE: rtl/ttu_step.sv
// One parse step: consumes a character, updates the state, may produce a result.
module ttu_step (
  input  ttu_pkg::parse_state_t  cur_state,
  input  logic [7:0]             ch,
  input  logic                   first,
  output ttu_pkg::parse_state_t  next_state,
  output ttu_pkg::parse_result_t result
);
  import ttu_pkg::*;

  parse_state_t st;
  logic [3:0]   pos;
  logic         is_digit;
  logic         is_sep;
  logic [3:0]   dig;
  logic [6:0]   pair_sum;
  logic [19:0]  micro_new;
  logic [38:0]  total;

  // Record start wipes the state before the character is handled
  assign st        = first ? '0 : cur_state;
  assign pos       = st.char_pos;
  assign is_digit  = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
  assign is_sep    = (pos == POS_SEP_0) || (pos == POS_SEP_1) || (pos == POS_SEP_2);
  assign dig       = ch[3:0];
  assign pair_sum  = st.pair_value + {3'b000, dig};
  assign micro_new = 20'(st.micro_part * 20'd10) + {16'h0000, dig};
  // Final total: one 19x20 multiply plus the fraction
  assign total     = {20'h00000, st.whole_seconds} * {19'h00000, US_PER_SEC}
                   + {19'h00000, micro_new};

  always_comb begin
    next_state = st;
    result     = '0;
    if (!st.skipping) begin
      next_state.char_pos = pos + 4'd1;
      if (is_sep) begin
        // separators pass unchecked
      end else if (!is_digit) begin
        result.valid         = 1'b1;
        result.status        = STAT_NON_DIGIT;
        result.fail_pos      = pos;
        next_state.skipping  = 1'b1;
      end else begin
        unique case (pos) inside
          POS_HOUR_HI, POS_MIN_HI, POS_SEC_HI: begin
            next_state.pair_value = 7'(dig) * 7'd10;
          end
          POS_HOUR_LO: begin
            next_state.pair_value    = pair_sum;
            next_state.whole_seconds = 19'(pair_sum) * SECS_PER_HOUR;
          end
          POS_MIN_LO: begin
            next_state.pair_value = pair_sum;
            if (pair_sum >= PAIR_LIMIT) begin
              result.valid        = 1'b1;
              result.status       = STAT_MINUTE;
              result.fail_pos     = pos;
              next_state.skipping = 1'b1;
            end else begin
              next_state.whole_seconds = st.whole_seconds + 19'(pair_sum) * SECS_PER_MIN;
            end
          end
          POS_SEC_LO: begin
            next_state.pair_value = pair_sum;
            if (pair_sum >= PAIR_LIMIT) begin
              result.valid        = 1'b1;
              result.status       = STAT_SECOND;
              result.fail_pos     = pos;
              next_state.skipping = 1'b1;
            end else begin
              next_state.whole_seconds = st.whole_seconds + 19'(pair_sum);
            end
          end
          default: begin
            // microsecond digits
            next_state.micro_part = micro_new;
            if (pos >= POS_LAST) begin
              result.valid        = 1'b1;
              result.status       = STAT_OK;
              result.total_us     = total;
              result.fail_pos     = POS_LAST;
              next_state.skipping = 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule
